FILE: src/kcs_pkg.sv
// Shared types and constants for the keypad contact search block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package kcs_pkg;

  // Input item kinds.
  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_END  = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_PATTERN_DIGITS = 1'b0;
  localparam logic CFG_PATTERN_LENGTH = 1'b1;

  // Character codes used by the line filter and the keypad mapping.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CASE_BIT = 8'h20;

  // Saturation value of the matched contact count.
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // One input item as held in the input register.
  typedef struct packed {
    logic       req_type;
    logic [7:0] char_code;
    logic       number_line;
  } kcs_item_t;

  // Classified character: cut flag and the code that goes to the matcher.
  typedef struct packed {
    logic       cut;
    logic [7:0] code;
  } kcs_char_t;

  // One result item.
  typedef struct packed {
    logic        contact_match;
    logic [15:0] match_count;
  } kcs_result_t;

endpackage

FILE: src/kcs_char_class.sv
// Character classification: line cut detection and keypad digit mapping.
// Depends on kcs_pkg.
`timescale 1ns / 1ps

module kcs_char_class import kcs_pkg::*; (
  input  kcs_item_t item,
  output kcs_char_t chr
);

  logic [7:0] lower;
  logic [7:0] mapped;
  logic       is_letter;

  // Fold upper case onto lower case before the keypad lookup.
  always_comb begin
    if (item.char_code >= CH_UP_A && item.char_code <= CH_UP_Z) begin
      lower = item.char_code | CASE_BIT;
    end else begin
      lower = item.char_code;
    end
    is_letter = (lower >= CH_LO_A) && (lower <= CH_LO_Z);
  end

  // Letters map to the keypad digit that carries them; others pass unchanged.
  always_comb begin
    if (!is_letter) begin
      mapped = item.char_code;
    end else if (lower <= CH_LO_A + 8'd2) begin
      mapped = CH_TWO;
    end else if (lower <= CH_LO_A + 8'd5) begin
      mapped = CH_TWO + 8'd1;
    end else if (lower <= CH_LO_A + 8'd8) begin
      mapped = CH_TWO + 8'd2;
    end else if (lower <= CH_LO_A + 8'd11) begin
      mapped = CH_TWO + 8'd3;
    end else if (lower <= CH_LO_A + 8'd14) begin
      mapped = CH_TWO + 8'd4;
    end else if (lower <= CH_LO_A + 8'd18) begin
      mapped = CH_TWO + 8'd5;
    end else if (lower <= CH_LO_A + 8'd21) begin
      mapped = CH_TWO + 8'd6;
    end else begin
      mapped = CH_NINE;
    end
  end

  // Name lines stop at a plus sign, number lines at a carriage return; both stop at a line feed or a NUL.
  always_comb begin
    if (item.number_line) begin
      chr.cut  = (item.char_code == CH_CR) || (item.char_code == CH_LF) ||
                 (item.char_code == CH_NUL);
      chr.code = item.char_code;
    end else begin
      chr.cut  = (item.char_code == CH_PLUS) || (item.char_code == CH_LF) ||
                 (item.char_code == CH_NUL);
      chr.code = mapped;
    end
  end

endmodule

FILE: src/kcs_match_core.sv
// Shift-and matcher state: partial match vector, line cut, hit flag and count.
// Depends on kcs_pkg; fed by kcs_char_class.
`timescale 1ns / 1ps

module kcs_match_core import kcs_pkg::*; #(
  parameter int PATTERN_MAX = 16,
  parameter int LEN_W       = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  kcs_item_t         item,
  input  kcs_char_t         chr,
  input  logic [63:0]       pattern_digits,
  input  logic [LEN_W-1:0]  used_len,
  output kcs_result_t       result
);

  logic [PATTERN_MAX-1:0] partial_match_vector;
  logic [PATTERN_MAX-1:0] vector_next;
  logic [PATTERN_MAX-1:0] char_mask;
  logic [PATTERN_MAX-1:0] last_bit;
  logic                   line_cut;
  logic                   name_hit;
  logic [15:0]            matched_contacts;
  logic [15:0]            count_next;
  logic                   hit;

  // Per-position compare of the character against the query digits.
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      char_mask[i] = (LEN_W'(i) < used_len) &&
                     (pattern_digits[4*i +: 4] <= 4'd9) &&
                     (chr.code == (CH_ZERO | {4'b0, pattern_digits[4*i +: 4]}));
      last_bit[i]  = (LEN_W'(i + 1) == used_len);
    end
    vector_next = ((partial_match_vector << 1) | PATTERN_MAX'(1)) & char_mask;
  end

  // Result of an end-of-contact item, from the state before this item.
  always_comb begin
    hit = name_hit || (used_len == '0);
    if (hit && matched_contacts != COUNT_MAX) begin
      count_next = matched_contacts + 16'd1;
    end else begin
      count_next = matched_contacts;
    end
    result.contact_match = hit;
    result.match_count   = count_next;
  end

  // State update, one item per cycle on each fire.
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_match_vector <= '0;
      line_cut             <= 1'b0;
      name_hit             <= 1'b0;
      matched_contacts     <= '0;
    end else if (fire) begin
      if (item.req_type == REQ_CHAR) begin
        if (!line_cut) begin
          if (chr.cut) begin
            line_cut <= 1'b1;
          end else if (used_len != '0) begin
            partial_match_vector <= vector_next;
            if ((vector_next & last_bit) != '0) begin
              name_hit <= 1'b1;
            end
          end
        end
      end else begin
        partial_match_vector <= '0;
        line_cut             <= 1'b0;
        if (item.number_line) begin
          matched_contacts <= count_next;
          name_hit         <= 1'b0;
        end
      end
    end
  end

`ifndef SYNTHESIS
  // An end item leaves a clean line state behind.
  assert property (@(posedge clk) disable iff (rst)
    fire && item.req_type == REQ_END |=> partial_match_vector == '0 && !line_cut)
    else $error("line state not cleared at end of line");

  // The contact count never goes down.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> matched_contacts >= $past(matched_contacts))
    else $error("matched contact count decreased");

  // A cut line leaves the match vector alone.
  assert property (@(posedge clk) disable iff (rst)
    fire && line_cut && item.req_type == REQ_CHAR |=> $stable(partial_match_vector))
    else $error("match vector changed on a cut line");
`endif

endmodule

FILE: src/keypad_contact_search_unit.sv
// Top level of the keypad contact search block: input register, config
// registers, output register. Depends on kcs_pkg, kcs_char_class, kcs_match_core.
`timescale 1ns / 1ps

// Usage:
// Contact records stream in one character item per cycle on the input channel
// (in_valid / in_stall): a name line, then a number line, each closed by an
// end-of-line item. At the end of every number line one result item leaves on
// the output channel (out_valid / out_stall) with the match flag and the
// saturating count of matched contacts. Other items give no result.
// Path: an item is held in the input register and processed there; its result
// is registered in the output register. Throughput: one item per cycle while
// no end-of-contact item waits on a stalled output, set by the single
// registered pass through the classifier and the shift-and update. The pattern
// registers are written through cfg_write / cfg_index / cfg_data while the
// block is idle, a duty of the user, not enforced by the block. Reset clears
// the match state, the count and both pattern registers; no clearing pass is
// needed. When out_stall holds a result, the input register can still drain
// items that give no result; an end-of-contact item waits and in_stall rises.

module keypad_contact_search_unit import kcs_pkg::*; #(
  parameter int PATTERN_MAX = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [7:0]  char_code,
  input  logic        number_line,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        contact_match,
  output logic [15:0] match_count
);

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);

  logic [63:0]      pattern_digits;
  logic [4:0]       pattern_length;
  logic [LEN_W-1:0] used_len;

  kcs_item_t   s1_item;
  logic        s1_valid;
  logic        s1_produces;
  logic        s1_fire;
  logic        out_free;
  kcs_char_t   chr;
  kcs_result_t result;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_digits <= '0;
      pattern_length <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_PATTERN_DIGITS: pattern_digits <= cfg_data;
        CFG_PATTERN_LENGTH: pattern_length <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // A length above the vector width is taken as the full width.
  always_comb begin
    if (pattern_length > 5'(PATTERN_MAX)) begin
      used_len = LEN_W'(PATTERN_MAX);
    end else begin
      used_len = LEN_W'(pattern_length);
    end
  end

  // Flow control: only an end-of-contact item needs room at the output.
  assign out_free    = !out_valid || !out_stall;
  assign s1_produces = (s1_item.req_type == REQ_END) && s1_item.number_line;
  assign s1_fire     = s1_valid && (!s1_produces || out_free);
  assign in_stall    = s1_valid && !s1_fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item.req_type    <= req_type;
      s1_item.char_code   <= char_code;
      s1_item.number_line <= number_line;
    end
  end

  kcs_char_class u_char_class (
    .item (s1_item),
    .chr  (chr)
  );

  kcs_match_core #(
    .PATTERN_MAX (PATTERN_MAX),
    .LEN_W       (LEN_W)
  ) u_match_core (
    .clk            (clk),
    .rst            (rst),
    .fire           (s1_fire),
    .item           (s1_item),
    .chr            (chr),
    .pattern_digits (pattern_digits),
    .used_len       (used_len),
    .result         (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_fire && s1_produces;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_produces) begin
      contact_match <= result.contact_match;
      match_count   <= result.match_count;
    end
  end

`ifndef SYNTHESIS
  // A matched contact is always counted.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && contact_match |-> match_count != 16'd0)
    else $error("match reported with zero count");

  // The input side only stalls behind a held end-of-contact item.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && s1_produces && out_valid && out_stall)
    else $error("input stalled without cause");

  // A taken result with nothing new behind it empties the output register.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !(s1_fire && s1_produces) |=> !out_valid)
    else $error("result item repeated");
`endif

endmodule
